[design/mpbp_pkg.sv]
package mpbp_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned ClassWidth  = 3;
   localparam int unsigned TypeWidth   = 4;
   localparam int unsigned LengthWidth = 28;
   localparam int unsigned TopicWidth  = 16;
   localparam int unsigned ErrorWidth  = 2;

   // byte classes
   localparam logic [ClassWidth-1:0] CLASS_HEADER     = 3'd0;
   localparam logic [ClassWidth-1:0] CLASS_LENGTH     = 3'd1;
   localparam logic [ClassWidth-1:0] CLASS_TOPIC_LEN  = 3'd2;
   localparam logic [ClassWidth-1:0] CLASS_TOPIC      = 3'd3;
   localparam logic [ClassWidth-1:0] CLASS_PAYLOAD    = 3'd4;
   localparam logic [ClassWidth-1:0] CLASS_DISCARDED  = 3'd5;

   // error codes
   localparam logic [ErrorWidth-1:0] ERR_NONE         = 2'd0;
   localparam logic [ErrorWidth-1:0] ERR_LENGTH_LONG  = 2'd1;
   localparam logic [ErrorWidth-1:0] ERR_TOPIC_OVER   = 2'd2;

   typedef struct packed {
      logic [ByteWidth-1:0]   out_byte;
      logic [ClassWidth-1:0]  byte_class;
      logic [TypeWidth-1:0]   packet_type;
      logic [LengthWidth-1:0] remaining_length;
      logic [TopicWidth-1:0]  topic_length;
      logic [LengthWidth-1:0] payload_length;
      logic                   last_of_packet;
      logic [ErrorWidth-1:0]  error_code;
   } result_type;

endpackage

[design/mpbp_parse_core.sv]
module mpbp_parse_core
   import mpbp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [ByteWidth-1:0] in_byte,
   output result_type           result
);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_LENGTH  = 3'd1,
      PH_TLEN_HI = 3'd2,
      PH_TLEN_LO = 3'd3,
      PH_TOPIC   = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_DISCARD = 3'd6
   } phase_type;

   phase_type              phase_ff,      phase_in;
   logic [TypeWidth-1:0]   type_ff,       type_in;
   logic [LengthWidth-1:0] length_acc_ff, length_acc_in;
   logic [1:0]             length_idx_ff, length_idx_in;
   logic [LengthWidth-1:0] bytes_left_ff, bytes_left_in;
   logic [TopicWidth-1:0]  topic_len_ff,  topic_len_in;
   logic [TopicWidth-1:0]  topic_left_ff, topic_left_in;

   logic [LengthWidth-1:0] length_add;
   logic [LengthWidth-1:0] acc_sum;
   logic [LengthWidth-1:0] bytes_dec;
   logic [TopicWidth-1:0]  topic_dec;
   logic [TopicWidth-1:0]  tlen_full;
   logic [LengthWidth-1:0] plen_reg;
   logic [LengthWidth-1:0] plen_full;

   // seven-bit group placed at its weight
   always_comb begin
      case (length_idx_ff)
         2'd0:    length_add = {21'b0, in_byte[6:0]};
         2'd1:    length_add = {14'b0, in_byte[6:0], 7'b0};
         2'd2:    length_add = {7'b0, in_byte[6:0], 14'b0};
         2'd3:    length_add = {in_byte[6:0], 21'b0};
         default: length_add = {21'b0, in_byte[6:0]};
      endcase
   end

   assign acc_sum   = length_acc_ff + length_add;
   assign bytes_dec = bytes_left_ff - LengthWidth'(1);
   assign topic_dec = topic_left_ff - TopicWidth'(1);
   assign tlen_full = {topic_len_ff[15:8], in_byte};
   assign plen_reg  = length_acc_ff - LengthWidth'(2) - LengthWidth'(topic_len_ff);
   assign plen_full = length_acc_ff - LengthWidth'(2) - LengthWidth'(tlen_full);

   always_comb begin
      phase_in      = phase_ff;
      type_in       = type_ff;
      length_acc_in = length_acc_ff;
      length_idx_in = length_idx_ff;
      bytes_left_in = bytes_left_ff;
      topic_len_in  = topic_len_ff;
      topic_left_in = topic_left_ff;

      result.out_byte         = in_byte;
      result.byte_class       = CLASS_HEADER;
      result.packet_type      = type_ff;
      result.remaining_length = length_acc_ff;
      result.topic_length     = '0;
      result.payload_length   = '0;
      result.last_of_packet   = 1'b0;
      result.error_code       = ERR_NONE;

      case (phase_ff)
         PH_LENGTH: begin
            result.byte_class       = CLASS_LENGTH;
            length_acc_in           = acc_sum;
            result.remaining_length = acc_sum;
            if (in_byte[7]) begin
               if (length_idx_ff == 2'd3) begin
                  result.error_code     = ERR_LENGTH_LONG;
                  result.last_of_packet = 1'b1;
                  phase_in              = PH_HEADER;
               end else begin
                  length_idx_in = length_idx_ff + 2'd1;
               end
            end else begin
               bytes_left_in = acc_sum;
               if (acc_sum == '0) begin
                  result.last_of_packet = 1'b1;
                  phase_in              = PH_HEADER;
               end else begin
                  phase_in = PH_TLEN_HI;
               end
            end
         end
         PH_TLEN_HI: begin
            result.byte_class = CLASS_TOPIC_LEN;
            topic_len_in      = {in_byte, 8'b0};
            bytes_left_in     = bytes_dec;
            if (bytes_dec == '0) begin
               result.error_code     = ERR_TOPIC_OVER;
               result.last_of_packet = 1'b1;
               phase_in              = PH_HEADER;
            end else begin
               phase_in = PH_TLEN_LO;
            end
         end
         PH_TLEN_LO: begin
            result.byte_class   = CLASS_TOPIC_LEN;
            topic_len_in        = tlen_full;
            result.topic_length = tlen_full;
            bytes_left_in       = bytes_dec;
            if (LengthWidth'(tlen_full) > bytes_dec) begin
               result.error_code = ERR_TOPIC_OVER;
               if (bytes_dec == '0) begin
                  result.last_of_packet = 1'b1;
                  phase_in              = PH_HEADER;
               end else begin
                  phase_in = PH_DISCARD;
               end
            end else begin
               result.payload_length = plen_full;
               topic_left_in         = tlen_full;
               if (bytes_dec == '0) begin
                  result.last_of_packet = 1'b1;
                  phase_in              = PH_HEADER;
               end else if (tlen_full != '0) begin
                  phase_in = PH_TOPIC;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_TOPIC: begin
            result.byte_class     = CLASS_TOPIC;
            result.topic_length   = topic_len_ff;
            result.payload_length = plen_reg;
            bytes_left_in         = bytes_dec;
            topic_left_in         = topic_dec;
            if (bytes_dec == '0) begin
               result.last_of_packet = 1'b1;
               phase_in              = PH_HEADER;
            end else if (topic_dec == '0) begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            result.byte_class     = CLASS_PAYLOAD;
            result.topic_length   = topic_len_ff;
            result.payload_length = plen_reg;
            bytes_left_in         = bytes_dec;
            if (bytes_dec == '0) begin
               result.last_of_packet = 1'b1;
               phase_in              = PH_HEADER;
            end
         end
         PH_DISCARD: begin
            result.byte_class   = CLASS_DISCARDED;
            result.topic_length = topic_len_ff;
            bytes_left_in       = bytes_dec;
            if (bytes_dec == '0) begin
               result.last_of_packet = 1'b1;
               phase_in              = PH_HEADER;
            end
         end
         default: begin
            // header byte, also any unused phase code
            result.byte_class       = CLASS_HEADER;
            type_in                 = in_byte[7:4];
            result.packet_type      = in_byte[7:4];
            result.remaining_length = '0;
            length_acc_in           = '0;
            length_idx_in           = '0;
            bytes_left_in           = '0;
            topic_len_in            = '0;
            topic_left_in           = '0;
            phase_in                = PH_LENGTH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         type_ff       <= '0;
         length_acc_ff <= '0;
         length_idx_ff <= '0;
         bytes_left_ff <= '0;
         topic_len_ff  <= '0;
         topic_left_ff <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         type_ff       <= type_in;
         length_acc_ff <= length_acc_in;
         length_idx_ff <= length_idx_in;
         bytes_left_ff <= bytes_left_in;
         topic_len_ff  <= topic_len_in;
         topic_left_ff <= topic_left_in;
      end
   end

`ifndef SYNTHESIS
   a_len_error_ends_packet: assert property (@(posedge clock) disable iff (reset)
      fire && result.error_code == ERR_LENGTH_LONG |-> result.last_of_packet)
      else $error("length error without end of packet");

   a_last_returns_to_header: assert property (@(posedge clock) disable iff (reset)
      fire && result.last_of_packet |=> phase_ff == PH_HEADER)
      else $error("packet end did not return to header phase");

   a_header_starts_length: assert property (@(posedge clock) disable iff (reset)
      fire && result.byte_class == CLASS_HEADER |=> phase_ff == PH_LENGTH)
      else $error("header byte not followed by length phase");

   a_idle_holds_phase: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(phase_ff))
      else $error("phase moved without a transaction");
`endif

endmodule

[design/mqtt_publish_byte_parser.sv]
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_in_byte
// rsp      out        rsp_valid/rsp_stall   rsp_out_byte .. rsp_error_code
//
// one transaction in gives one transaction out, one byte per cycle sustained while rsp is not stalled
// each byte passes the input register, then parse logic into the result register
// the parse state advances only when a byte moves into the result register
// reset (synchronous, active high) empties both registers and sets header phase
// a stall on rsp holds the result; the input register still fills behind it
module mqtt_publish_byte_parser
   import mpbp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ByteWidth-1:0]   req_in_byte,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ByteWidth-1:0]   rsp_out_byte,
   output logic [ClassWidth-1:0]  rsp_byte_class,
   output logic [TypeWidth-1:0]   rsp_packet_type,
   output logic [LengthWidth-1:0] rsp_remaining_length,
   output logic [TopicWidth-1:0]  rsp_topic_length,
   output logic [LengthWidth-1:0] rsp_payload_length,
   output logic                   rsp_last_of_packet,
   output logic [ErrorWidth-1:0]  rsp_error_code
);

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff;

   logic                 req_take;
   logic                 advance;
   logic                 fire;
   result_type           parsed;

   // result register can load when empty or being drained this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   mpbp_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (in_byte_ff),
      .result  (parsed)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
      if (fire) begin
         rsp_ff <= parsed;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_byte         = rsp_ff.out_byte;
   assign rsp_byte_class       = rsp_ff.byte_class;
   assign rsp_packet_type      = rsp_ff.packet_type;
   assign rsp_remaining_length = rsp_ff.remaining_length;
   assign rsp_topic_length     = rsp_ff.topic_length;
   assign rsp_payload_length   = rsp_ff.payload_length;
   assign rsp_last_of_packet   = rsp_ff.last_of_packet;
   assign rsp_error_code       = rsp_ff.error_code;

endmodule
